[design/oobfd_pkg.sv]
`default_nettype none

package oobfd_pkg;

   // Frame geometry
   localparam int FRAME_LEN    = 74;
   localparam int CRC_SPAN     = 70;
   localparam int MAGIC_LEN    = 4;
   localparam int POS_SCHEMA   = 4;
   localparam int POS_ROLE     = 5;
   localparam int POS_LEN_LO   = 6;
   localparam int POS_LEN_HI   = 7;
   localparam int POS_ID_TYPE  = 8;
   localparam int POS_ID_ADDR  = 9;
   localparam int POS_P_TYPE   = 15;
   localparam int POS_P_ADDR   = 16;
   localparam int ADDR_BYTES   = 6;
   localparam int SECRET_POS   = 22;
   localparam int NONCE_POS    = 54;
   localparam int SECRET_BYTES = CRC_SPAN - SECRET_POS;
   localparam int CHUNK_W      = 64;
   localparam int CHUNKS       = SECRET_BYTES * 8 / CHUNK_W;
   localparam int CRC_BYTES    = FRAME_LEN - CRC_SPAN;

   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   localparam logic [7:0] MAGIC [MAGIC_LEN] = '{8'h4E, 8'h33, 8'h30, 8'h4F};

   // Configuration register indexes
   localparam logic [1:0] CSR_SCHEMA  = 2'd0;
   localparam logic [1:0] CSR_PERIPH  = 2'd1;
   localparam logic [1:0] CSR_CENTRAL = 2'd2;

   typedef logic [6:0] count_type;
   typedef logic [2:0] chunk_type;

   localparam chunk_type LAST_CHUNK = chunk_type'(CHUNKS - 1);

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_LENGTH   = 3'd1,
      ST_MAGIC    = 3'd2,
      ST_LENFIELD = 3'd3,
      ST_CRC      = 3'd4,
      ST_RECORD   = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] schema;
      logic [7:0] periph;
      logic [7:0] central;
   } cfg_type;

   typedef struct packed {
      status_type                    status;
      logic [7:0]                    schema;
      logic [7:0]                    role;
      logic                          id_type;
      logic [8*ADDR_BYTES-1:0]       id_addr;
      logic                          p_type;
      logic [8*ADDR_BYTES-1:0]       p_addr;
      logic [8*SECRET_BYTES-1:0]     secret;
   } job_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[design/oobfd_if.sv]
`default_nettype none

interface oobfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, frame_byte, frame_end, input ready);
   modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface oobfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  schema;
   logic [7:0]  role;
   logic        identity_type;
   logic [47:0] identity_addr;
   logic        pairing_type;
   logic [47:0] pairing_addr;
   logic [2:0]  chunk_index;
   logic [63:0] chunk_data;
   logic        run_last;

   modport source (output valid, status, schema, role, identity_type, identity_addr,
                   pairing_type, pairing_addr, chunk_index, chunk_data, run_last,
                   input ready);
   modport sink   (input valid, status, schema, role, identity_type, identity_addr,
                   pairing_type, pairing_addr, chunk_index, chunk_data, run_last,
                   output ready);
endinterface

`default_nettype wire

[design/oobfd_front.sv]
`default_nettype none

module oobfd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   oobfd_req_if.sink               req,
   input  wire oobfd_pkg::cfg_type cfg,
   input  wire logic               q_ready,
   output logic                    q_push,
   output oobfd_pkg::job_type      q_job
);

   oobfd_pkg::count_type cnt_ff, cnt_in;
   logic [31:0]          crc_ff, crc_in;
   logic [31:0]          rcrc_ff, rcrc_in;
   logic                 magic_ff, magic_in;
   logic                 nonce_ff, nonce_in;
   logic                 overrun_ff, overrun_in;

   logic [7:0]           schema_ff, schema_in;
   logic [7:0]           role_ff, role_in;
   logic [7:0]           len_lo_ff, len_lo_in;
   logic [7:0]           len_hi_ff, len_hi_in;
   logic [7:0]           id_type_ff, id_type_in;
   logic [7:0]           p_type_ff, p_type_in;
   logic [8*oobfd_pkg::ADDR_BYTES-1:0]   id_addr_ff, id_addr_in;
   logic [8*oobfd_pkg::ADDR_BYTES-1:0]   p_addr_ff, p_addr_in;
   logic [8*oobfd_pkg::SECRET_BYTES-1:0] sec_ff, sec_in;

   logic                 acc;
   logic                 rec_ok;
   oobfd_pkg::count_type p;
   logic [7:0]           b;

   assign req.ready = q_ready;
   assign acc       = req.valid && req.ready;
   assign p         = cnt_ff;
   assign b         = req.frame_byte;

   always_comb begin
      cnt_in     = cnt_ff;
      crc_in     = crc_ff;
      rcrc_in    = rcrc_ff;
      magic_in   = magic_ff;
      nonce_in   = nonce_ff;
      overrun_in = overrun_ff;
      schema_in  = schema_ff;
      role_in    = role_ff;
      len_lo_in  = len_lo_ff;
      len_hi_in  = len_hi_ff;
      id_type_in = id_type_ff;
      p_type_in  = p_type_ff;
      id_addr_in = id_addr_ff;
      p_addr_in  = p_addr_ff;
      sec_in     = sec_ff;
      q_push     = 1'b0;
      q_job      = '0;
      rec_ok     = 1'b0;

      if (acc) begin
         if (p >= oobfd_pkg::count_type'(oobfd_pkg::FRAME_LEN)) begin
            // drop the beat, the frame is already too long
            overrun_in = 1'b1;
         end else begin
            cnt_in = p + 1'b1;
            if (p < oobfd_pkg::count_type'(oobfd_pkg::CRC_SPAN)) begin
               crc_in = oobfd_pkg::crc_byte(crc_ff, b);
               if (p < oobfd_pkg::count_type'(oobfd_pkg::MAGIC_LEN) &&
                   b != oobfd_pkg::MAGIC[p[1:0]]) begin
                  magic_in = 1'b0;
               end
               if (p >= oobfd_pkg::count_type'(oobfd_pkg::NONCE_POS) && b != 8'd0) begin
                  nonce_in = 1'b1;
               end
               if (p >= oobfd_pkg::count_type'(oobfd_pkg::SECRET_POS)) begin
                  sec_in = {b, sec_ff[8*oobfd_pkg::SECRET_BYTES-1:8]};
               end
            end
            for (int i = 0; i < oobfd_pkg::CRC_BYTES; i++) begin
               if (p == oobfd_pkg::count_type'(oobfd_pkg::CRC_SPAN + i)) rcrc_in[8*i +: 8] = b;
            end
            for (int i = 0; i < oobfd_pkg::ADDR_BYTES; i++) begin
               if (p == oobfd_pkg::count_type'(oobfd_pkg::POS_ID_ADDR + i))
                  id_addr_in[8*i +: 8] = b;
               if (p == oobfd_pkg::count_type'(oobfd_pkg::POS_P_ADDR + i))
                  p_addr_in[8*i +: 8] = b;
            end
            if (p == oobfd_pkg::count_type'(oobfd_pkg::POS_SCHEMA))  schema_in  = b;
            if (p == oobfd_pkg::count_type'(oobfd_pkg::POS_ROLE))    role_in    = b;
            if (p == oobfd_pkg::count_type'(oobfd_pkg::POS_LEN_LO))  len_lo_in  = b;
            if (p == oobfd_pkg::count_type'(oobfd_pkg::POS_LEN_HI))  len_hi_in  = b;
            if (p == oobfd_pkg::count_type'(oobfd_pkg::POS_ID_TYPE)) id_type_in = b;
            if (p == oobfd_pkg::count_type'(oobfd_pkg::POS_P_TYPE))  p_type_in  = b;
         end
      end

      rec_ok = schema_in == cfg.schema &&
               (role_in == cfg.periph || role_in == cfg.central) &&
               id_type_in <= 8'd1 && p_type_in <= 8'd1 && nonce_in;

      q_job.schema  = schema_in;
      q_job.role    = role_in;
      q_job.id_type = id_type_in[0];
      q_job.id_addr = id_addr_in;
      q_job.p_type  = p_type_in[0];
      q_job.p_addr  = p_addr_in;
      q_job.secret  = sec_in;

      priority if (overrun_in || cnt_in != oobfd_pkg::count_type'(oobfd_pkg::FRAME_LEN))
         q_job.status = oobfd_pkg::ST_LENGTH;
      else if (!magic_in)
         q_job.status = oobfd_pkg::ST_MAGIC;
      else if (len_lo_in != 8'(oobfd_pkg::FRAME_LEN) || len_hi_in != 8'd0)
         q_job.status = oobfd_pkg::ST_LENFIELD;
      else if (~crc_in != rcrc_in)
         q_job.status = oobfd_pkg::ST_CRC;
      else if (!rec_ok)
         q_job.status = oobfd_pkg::ST_RECORD;
      else
         q_job.status = oobfd_pkg::ST_OK;

      if (acc && req.frame_end) begin
         // hand the frame over and start afresh
         q_push     = 1'b1;
         cnt_in     = '0;
         crc_in     = oobfd_pkg::CRC_INIT;
         rcrc_in    = '0;
         magic_in   = 1'b1;
         nonce_in   = 1'b0;
         overrun_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         crc_ff     <= oobfd_pkg::CRC_INIT;
         rcrc_ff    <= '0;
         magic_ff   <= 1'b1;
         nonce_ff   <= 1'b0;
         overrun_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         crc_ff     <= crc_in;
         rcrc_ff    <= rcrc_in;
         magic_ff   <= magic_in;
         nonce_ff   <= nonce_in;
         overrun_ff <= overrun_in;
      end
   end

   always_ff @(posedge clock) begin
      schema_ff  <= schema_in;
      role_ff    <= role_in;
      len_lo_ff  <= len_lo_in;
      len_hi_ff  <= len_hi_in;
      id_type_ff <= id_type_in;
      p_type_ff  <= p_type_in;
      id_addr_ff <= id_addr_in;
      p_addr_ff  <= p_addr_in;
      sec_ff     <= sec_in;
   end

endmodule

`default_nettype wire

[design/oobfd_queue.sv]
`default_nettype none

module oobfd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire oobfd_pkg::job_type job_in,
   output logic                    not_full,
   input  wire logic               pop,
   output logic                    not_empty,
   output oobfd_pkg::job_type      job_out
);

   oobfd_pkg::job_type mem_ff [2];
   logic               wr_ff, wr_in;
   logic               rd_ff, rd_in;
   logic [1:0]         cnt_ff, cnt_in;

   assign not_full  = cnt_ff != 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign job_out   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop  ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= job_in;
   end

endmodule

`default_nettype wire

[design/oobfd_back.sv]
`default_nettype none

module oobfd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire oobfd_pkg::job_type job,
   output logic                    q_pop,
   oobfd_rsp_if.source             rsp
);

   logic                 vld_ff, vld_in;
   oobfd_pkg::chunk_type ck_ff, ck_in;
   logic [2:0]           status_ff, status_in;
   logic [7:0]           schema_ff, schema_in;
   logic [7:0]           role_ff, role_in;
   logic                 id_type_ff, id_type_in;
   logic [47:0]          id_addr_ff, id_addr_in;
   logic                 p_type_ff, p_type_in;
   logic [47:0]          p_addr_ff, p_addr_in;
   logic [2:0]           idx_ff, idx_in;
   logic [63:0]          data_ff, data_in;
   logic                 last_ff, last_in;

   logic load;
   logic ok;

   assign load = q_valid && (!vld_ff || rsp.ready);
   assign ok   = job.status == oobfd_pkg::ST_OK;

   always_comb begin
      status_in  = status_ff;
      schema_in  = schema_ff;
      role_in    = role_ff;
      id_type_in = id_type_ff;
      id_addr_in = id_addr_ff;
      p_type_in  = p_type_ff;
      p_addr_in  = p_addr_ff;
      idx_in     = idx_ff;
      data_in    = data_ff;
      last_in    = last_ff;
      vld_in     = vld_ff;
      ck_in      = ck_ff;
      q_pop      = 1'b0;

      if (load) begin
         vld_in    = 1'b1;
         status_in = job.status;
         if (ok) begin
            schema_in  = job.schema;
            role_in    = job.role;
            id_type_in = job.id_type;
            id_addr_in = job.id_addr;
            p_type_in  = job.p_type;
            p_addr_in  = job.p_addr;
            idx_in     = ck_ff;
            data_in    = '0;
            for (int i = 0; i < oobfd_pkg::CHUNKS; i++) begin
               if (ck_ff == oobfd_pkg::chunk_type'(i))
                  data_in = job.secret[oobfd_pkg::CHUNK_W*i +: oobfd_pkg::CHUNK_W];
            end
            last_in = ck_ff == oobfd_pkg::LAST_CHUNK;
         end else begin
            schema_in  = '0;
            role_in    = '0;
            id_type_in = 1'b0;
            id_addr_in = '0;
            p_type_in  = 1'b0;
            p_addr_in  = '0;
            idx_in     = '0;
            data_in    = '0;
            last_in    = 1'b1;
         end
         // retire the job once its last beat is loaded
         if (last_in) begin
            q_pop = 1'b1;
            ck_in = '0;
         end else begin
            ck_in = ck_ff + 1'b1;
         end
      end else if (rsp.ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         ck_ff  <= '0;
      end else begin
         vld_ff <= vld_in;
         ck_ff  <= ck_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      schema_ff  <= schema_in;
      role_ff    <= role_in;
      id_type_ff <= id_type_in;
      id_addr_ff <= id_addr_in;
      p_type_ff  <= p_type_in;
      p_addr_ff  <= p_addr_in;
      idx_ff     <= idx_in;
      data_ff    <= data_in;
      last_ff    <= last_in;
   end

   assign rsp.valid         = vld_ff;
   assign rsp.status        = status_ff;
   assign rsp.schema        = schema_ff;
   assign rsp.role          = role_ff;
   assign rsp.identity_type = id_type_ff;
   assign rsp.identity_addr = id_addr_ff;
   assign rsp.pairing_type  = p_type_ff;
   assign rsp.pairing_addr  = p_addr_ff;
   assign rsp.chunk_index   = idx_ff;
   assign rsp.chunk_data    = data_ff;
   assign rsp.run_last      = last_ff;

endmodule

`default_nettype wire

[design/oob_frame_decoder_unit.sv]
`default_nettype none

// Channel  Dir  Beat
// req_ch   in   one frame byte, frame_end on the final byte
// rsp_ch   out  one status beat on error, six chunk beats on success
// csr_*    in   write-only: schema, peripheral code, central code
//
// One byte per cycle on req_ch while the job queue has room; the CRC update,
// field capture and the final checks all finish in the cycle the byte is taken.
// A checked frame waits in a two-entry job queue; the result stage sends
// one beat per cycle while rsp_ch is ready, so a success run is six beats.
// req_ch stalls only while the job queue is full. Reset is synchronous
// and brings the CRC to all ones and the byte count to zero.
module oob_frame_decoder_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   oobfd_req_if.sink       req_ch,
   oobfd_rsp_if.source     rsp_ch,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   oobfd_pkg::cfg_type cfg_ff, cfg_in;
   oobfd_pkg::job_type push_job, head_job;
   logic               q_push, q_pop, q_not_full, q_not_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            oobfd_pkg::CSR_SCHEMA:  cfg_in.schema  = csr_wdata;
            oobfd_pkg::CSR_PERIPH:  cfg_in.periph  = csr_wdata;
            oobfd_pkg::CSR_CENTRAL: cfg_in.central = csr_wdata;
            default:                cfg_in         = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.schema  <= 8'd1;
         cfg_ff.periph  <= 8'd0;
         cfg_ff.central <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   oobfd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .cfg     (cfg_ff),
      .q_ready (q_not_full),
      .q_push  (q_push),
      .q_job   (push_job)
   );

   oobfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .job_in    (push_job),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .job_out   (head_job)
   );

   oobfd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_not_empty),
      .job     (head_job),
      .q_pop   (q_pop),
      .rsp     (rsp_ch)
   );

endmodule

`default_nettype wire
